@@ rtl/sapa_pkg.sv @@
// ----------------------------------------------------------------------------
// sapa_pkg
// Shared types and constants for the subnet address pool allocator.
// ----------------------------------------------------------------------------
package sapa_pkg;

    // pool geometry
    localparam int POOL_DEPTH = 256;
    localparam int SLOT_W     = $clog2(POOL_DEPTH);
    localparam int SIZE_W     = $clog2(POOL_DEPTH + 1);
    localparam int WORD_W     = (POOL_DEPTH < 64) ? POOL_DEPTH : 64;
    localparam int NUM_WORDS  = (POOL_DEPTH + WORD_W - 1) / WORD_W;
    localparam int MAP_BITS   = NUM_WORDS * WORD_W;
    localparam int MAP_IDX_W  = (MAP_BITS > 1) ? $clog2(MAP_BITS) : 1;
    localparam int WORD_IDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int POS_W      = (WORD_W > 1) ? $clog2(WORD_W) : 1;

    // field widths
    localparam int ADDR_W     = 32;
    localparam int SLOT_OUT_W = 8;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // register index as decoded from paddr[2]
    localparam logic REG_BASE_ADDRESS  = 1'b0;
    localparam logic REG_NETMASK_VALUE = 1'b1;

    localparam logic [ADDR_W-1:0] BASE_RESET = 32'hC0A8_0100;
    localparam logic [ADDR_W-1:0] MASK_RESET = 32'hFFFF_FF00;

    // input commands
    localparam logic CMD_ALLOCATE = 1'b0;
    localparam logic CMD_RELEASE  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_ALLOCATED = 2'd0,
        STATUS_EXHAUSTED = 2'd1,
        STATUS_RELEASED  = 2'd2,
        STATUS_IGNORED   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_IGNORE  = 2'd2
    } op_kind_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_SCAN = 1'b1
    } back_state_t;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] release_address;
    } in_item_t;

    typedef struct packed {
        status_t               status;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [ADDR_W-1:0]     granted_address;
    } out_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] base_address;
        logic [ADDR_W-1:0] netmask_value;
    } cfg_t;

    // classified work item between front and back
    typedef struct packed {
        op_kind_t          kind;
        logic [SLOT_W-1:0] slot;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] net_plus1;
    } work_t;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

@@ rtl/sapa_cfg.sv @@
// ----------------------------------------------------------------------------
// sapa_cfg
// APB register file holding the subnet base address and netmask.
// ----------------------------------------------------------------------------
module sapa_cfg
    import sapa_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (paddr[2])
                REG_BASE_ADDRESS:  cfg_next.base_address  = pwdata;
                REG_NETMASK_VALUE: cfg_next.netmask_value = pwdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.base_address  <= BASE_RESET;
            cfg_reg.netmask_value <= MASK_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign prdata = (paddr[2] == REG_NETMASK_VALUE) ? cfg_reg.netmask_value
                                                    : cfg_reg.base_address;
    assign cfg    = cfg_reg;

endmodule

@@ rtl/sapa_front.sv @@
// ----------------------------------------------------------------------------
// sapa_front
// Classifies a request against the subnet: pool size, release range check.
// ----------------------------------------------------------------------------
module sapa_front
    import sapa_pkg::*;
(
    input  cfg_t     cfg,
    input  in_item_t item,
    output work_t    work
);

    logic [ADDR_W-1:0] network;
    logic [ADDR_W-1:0] broadcast;
    logic [ADDR_W-1:0] hosts;
    logic [ADDR_W-1:0] rel_off;
    logic [SIZE_W-1:0] size;
    logic              in_range;

    assign network   = cfg.base_address & cfg.netmask_value;
    assign broadcast = network | ~cfg.netmask_value;
    assign hosts     = ~cfg.netmask_value;
    assign rel_off   = item.release_address - network - 32'd1;

    // usable host slots, saturated to the bitmap depth
    always_comb begin
        if (hosts < 32'd2) begin
            size = '0;
        end else if ((hosts - 32'd1) > 32'(POOL_DEPTH)) begin
            size = SIZE_W'(POOL_DEPTH);
        end else begin
            size = SIZE_W'(hosts - 32'd1);
        end
    end

    assign in_range = (item.release_address > network)
                   && (item.release_address < broadcast)
                   && (rel_off < 32'(size));

    always_comb begin
        work.size      = size;
        work.net_plus1 = network + 32'd1;
        work.slot      = SLOT_W'(rel_off);
        if (item.cmd == CMD_ALLOCATE) begin
            work.kind = OP_ALLOC;
        end else if (in_range) begin
            work.kind = OP_RELEASE;
        end else begin
            work.kind = OP_IGNORE;
        end
    end

endmodule

@@ rtl/sapa_queue.sv @@
// ----------------------------------------------------------------------------
// sapa_queue
// Two-entry queue of classified work items between front and back.
// ----------------------------------------------------------------------------
module sapa_queue
    import sapa_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  work_t push_data,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output work_t pop_data
);

    work_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/sapa_back.sv @@
// ----------------------------------------------------------------------------
// sapa_back
// Slot bitmap with word-wise lowest-free search and the result register.
// ----------------------------------------------------------------------------
module sapa_back
    import sapa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    input  work_t     q_data,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    back_state_t           state_reg;
    back_state_t           state_next;
    logic [MAP_BITS-1:0]   map_reg;
    logic [MAP_BITS-1:0]   map_next;
    logic [WORD_IDX_W-1:0] word_reg;
    logic [WORD_IDX_W-1:0] word_next;
    logic [SIZE_W-1:0]     size_reg;
    logic [ADDR_W-1:0]     net1_reg;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    out_item_t             m_data_reg;
    out_item_t             m_data_next;

    logic                  out_free;
    logic [WORD_W-1:0]     cur_word;
    logic [WORD_W-1:0]     cand;
    logic                  found;
    logic [POS_W-1:0]      pos;
    logic [MAP_IDX_W-1:0]  alloc_idx;
    logic                  last_word;

    assign out_free  = !m_valid_reg || m_ready;
    assign cur_word  = map_reg[int'(word_reg) * WORD_W +: WORD_W];
    assign last_word = (word_reg == WORD_IDX_W'(NUM_WORDS - 1));

    // free slots of the current word that lie inside the pool
    always_comb begin
        for (int j = 0; j < WORD_W; j++) begin
            cand[j] = !cur_word[j]
                   && ((int'(word_reg) * WORD_W + j) < int'(size_reg));
        end
    end

    // lowest set candidate
    always_comb begin
        pos = '0;
        for (int j = WORD_W - 1; j >= 0; j--) begin
            if (cand[j]) begin
                pos = POS_W'(j);
            end
        end
    end

    assign found     = |cand;
    assign alloc_idx = MAP_IDX_W'(int'(word_reg) * WORD_W + int'(pos));

    always_comb begin
        state_next   = state_reg;
        map_next     = map_reg;
        word_next    = word_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        q_pop        = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    case (q_data.kind)
                        OP_ALLOC: begin
                            state_next = BK_SCAN;
                            word_next  = '0;
                        end
                        OP_RELEASE: begin
                            map_next[MAP_IDX_W'(q_data.slot)] = 1'b0;
                            m_valid_next = 1'b1;
                            m_data_next.status          = STATUS_RELEASED;
                            m_data_next.slot_index      = SLOT_OUT_W'(q_data.slot);
                            m_data_next.granted_address = '0;
                        end
                        default: begin
                            m_valid_next = 1'b1;
                            m_data_next.status          = STATUS_IGNORED;
                            m_data_next.slot_index      = '0;
                            m_data_next.granted_address = '0;
                        end
                    endcase
                end
            end
            BK_SCAN: begin
                if (found) begin
                    map_next[alloc_idx] = 1'b1;
                    m_valid_next = 1'b1;
                    m_data_next.status          = STATUS_ALLOCATED;
                    m_data_next.slot_index      = SLOT_OUT_W'(alloc_idx);
                    m_data_next.granted_address = net1_reg + ADDR_W'(alloc_idx);
                    state_next = BK_IDLE;
                end else if (last_word) begin
                    m_valid_next = 1'b1;
                    m_data_next.status          = STATUS_EXHAUSTED;
                    m_data_next.slot_index      = '0;
                    m_data_next.granted_address = '0;
                    state_next = BK_IDLE;
                end else begin
                    word_next = word_reg + 1'b1;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            map_reg     <= '0;
            m_valid_reg <= 1'b0;
            word_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            map_reg     <= map_next;
            m_valid_reg <= m_valid_next;
            word_reg    <= word_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (q_pop) begin
            size_reg <= q_data.size;
            net1_reg <= q_data.net_plus1;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a scan only runs with the result register empty
    a_scan_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_SCAN |-> !m_valid_reg)
        else $error("scan running while a result is pending");

    // a granted slot is marked used afterwards
    a_grant_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_SCAN && found) |=> map_reg[$past(alloc_idx)])
        else $error("granted slot not marked used");

    // a released slot is free afterwards
    a_release_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_data.kind == OP_RELEASE)
            |=> !map_reg[$past(MAP_IDX_W'(q_data.slot))])
        else $error("released slot still marked used");

endmodule

@@ rtl/subnet_address_pool_allocator.sv @@
// ----------------------------------------------------------------------------
// subnet_address_pool_allocator
// Hands out host addresses of an IPv4 subnet from a bitmap of used slots.
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one transfer per request; cmd allocate takes the lowest free
//   slot, cmd release frees the slot of release_address
//   m_ channel: exactly one result transfer per request, in request order
//   apb port: base_address at 0x0, netmask_value at 0x4; write only while
//   the block is idle; pready is always high
// request flow
//   a request is classified and queued at its accept edge; the bitmap side
//   pops it once the result register is free and no scan is running; a
//   release result is registered at that pop, an allocate result when the
//   scan, one 64-bit word per cycle (4 words at 256 slots), ends; releases
//   sustain one per cycle while m_ready is high, allocates wait for the scan
// reset
//   aresetn low clears the bitmap (every slot free), the queue and the result
//   register, and loads the registers with 192.168.1.0 / 255.255.255.0
// stall
//   while m_ready is low the result is held; the queue keeps accepting until
//   its two entries are full, then s_ready drops
// ----------------------------------------------------------------------------
module subnet_address_pool_allocator
    import sapa_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_data,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_data,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t  cfg;
    work_t front_work;
    work_t q_data;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;
    logic  push;

    // subnet registers
    sapa_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // front: classify the request as it is accepted
    sapa_front u_front (
        .cfg  (cfg),
        .item (s_data),
        .work (front_work)
    );

    // accept whenever the queue has room
    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;

    sapa_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (front_work),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_data)
    );

    // back: bitmap update, free-slot scan and result register
    sapa_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
